FILE: hdl/cppt_pkg.sv
package cppt_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_BITS_DEF   = 16;
  localparam int RADIUS_BITS      = 34;
  localparam int CFG_IDX_W        = 3;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X,
    CFG_BOX_MAX_X,
    CFG_BOX_MIN_Y,
    CFG_BOX_MAX_Y,
    CFG_CENTER_X,
    CFG_CENTER_Y,
    CFG_OUTER_RADIUS_SQ,
    CFG_INNER_RADIUS_SQ
  } cfg_index_t;

endpackage

FILE: hdl/cppt_req_if.sv
interface cppt_req_if #(
  parameter int IDX_W      = $clog2(cppt_pkg::MAX_VERTICES_DEF),
  parameter int COORD_BITS = cppt_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [IDX_W-1:0]             vertex_index;
  logic                         last_vertex;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;

  modport source (output valid, func, vertex_index, last_vertex, x_coord, y_coord,
                  input ready);
  modport sink   (input valid, func, vertex_index, last_vertex, x_coord, y_coord,
                  output ready);
endinterface

FILE: hdl/cppt_rsp_if.sv
interface cppt_rsp_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

FILE: hdl/convex_polygon_point_test_top.sv
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    func, vertex_index, last_vertex, x_coord, y_coord
// rsp       out  valid/ready    inside_res
// cfg       in   cfg_write      cfg_index, cfg_data (write only)
//
// One transaction per cycle on req while req is ready. A vertex load is written
// on the cycle it is accepted and yields nothing; a point test yields its result
// through the four register stages of the edge-lane pipeline. Synchronous reset
// clears the valid bits, the vertex count and the configuration registers; the
// vertex store is not cleared. A stall at rsp backs up stage by stage, so empty
// stages keep filling and req stays ready until all four stages hold data.
module convex_polygon_point_test_top #(
  parameter int MAX_VERTICES = cppt_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = cppt_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  cppt_req_if.sink                req,
  cppt_rsp_if.source              rsp,
  input  logic                    cfg_write,
  input  cppt_pkg::cfg_index_t    cfg_index,
  input  logic [((COORD_BITS > cppt_pkg::RADIUS_BITS) ? COORD_BITS
                 : cppt_pkg::RADIUS_BITS)-1:0] cfg_data
);
  import cppt_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int SUM_W = PW + 1;
  localparam int CMP_W = (SUM_W > RADIUS_BITS) ? SUM_W : RADIUS_BITS;

  // Configuration registers.
  logic signed [COORD_BITS-1:0] box_min_x, box_max_x, box_min_y, box_max_y;
  logic signed [COORD_BITS-1:0] center_x, center_y;
  logic [RADIUS_BITS-1:0]       outer_radius_sq, inner_radius_sq;

  // Vertex store and count.
  logic signed [COORD_BITS-1:0] corner_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] corner_y [MAX_VERTICES];
  logic [CNT_W-1:0]             corner_count;

  // Pipeline control.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  logic load_acc;

  // Stage registers.
  logic                    s1_box_out, s2_box_out, s3_box_out;
  logic signed [DW-1:0]    s1_qx, s1_qy;
  logic signed [DW-1:0]    s1_ex [MAX_VERTICES];
  logic signed [DW-1:0]    s1_ey [MAX_VERTICES];
  logic signed [DW-1:0]    s1_dx [MAX_VERTICES];
  logic signed [DW-1:0]    s1_dy [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] s1_en, s2_en;
  logic signed [PW-1:0]    s2_pa [MAX_VERTICES];
  logic signed [PW-1:0]    s2_pb [MAX_VERTICES];
  logic signed [PW-1:0]    s2_sqx, s2_sqy;
  logic [MAX_VERTICES-1:0] s3_rej;
  logic [SUM_W-1:0]        s3_dist;
  logic                    inside_res;

  // Per-lane edge end point and lane enable, from the current store.
  logic signed [COORD_BITS-1:0] end_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] end_y [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]      lane_en;

  assign rdy4      = !v4 || rsp.ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign req.ready = rdy1;
  assign rsp.valid = v4;
  assign rsp.inside_res = inside_res;

  assign load_acc = req.valid && rdy1 && (req.func == FUNC_LOAD) &&
                    ({1'b0, req.vertex_index} < (IDX_W + 1)'(MAX_VERTICES));

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      // The last occupied lane closes the polygon back to vertex zero.
      if (i == MAX_VERTICES - 1 || CNT_W'(i + 1) == corner_count) begin
        end_x[i] = corner_x[0];
        end_y[i] = corner_y[0];
      end else begin
        end_x[i] = corner_x[(i + 1) % MAX_VERTICES];
        end_y[i] = corner_y[(i + 1) % MAX_VERTICES];
      end
      lane_en[i] = ((corner_count >= CNT_W'(3)) && (CNT_W'(i) < corner_count)) ||
                   ((corner_count == CNT_W'(2)) && (i == 0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x       <= '0;
      box_max_x       <= '0;
      box_min_y       <= '0;
      box_max_y       <= '0;
      center_x        <= '0;
      center_y        <= '0;
      outer_radius_sq <= '0;
      inner_radius_sq <= '0;
      corner_count    <= '0;
      v1              <= 1'b0;
      v2              <= 1'b0;
      v3              <= 1'b0;
      v4              <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_BOX_MIN_X:       box_min_x       <= cfg_data[COORD_BITS-1:0];
          CFG_BOX_MAX_X:       box_max_x       <= cfg_data[COORD_BITS-1:0];
          CFG_BOX_MIN_Y:       box_min_y       <= cfg_data[COORD_BITS-1:0];
          CFG_BOX_MAX_Y:       box_max_y       <= cfg_data[COORD_BITS-1:0];
          CFG_CENTER_X:        center_x        <= cfg_data[COORD_BITS-1:0];
          CFG_CENTER_Y:        center_y        <= cfg_data[COORD_BITS-1:0];
          CFG_OUTER_RADIUS_SQ: outer_radius_sq <= cfg_data[RADIUS_BITS-1:0];
          CFG_INNER_RADIUS_SQ: inner_radius_sq <= cfg_data[RADIUS_BITS-1:0];
          default: ;
        endcase
      end
      if (load_acc && req.last_vertex) begin
        corner_count <= CNT_W'(req.vertex_index) + CNT_W'(1);
      end
      if (rdy1) v1 <= req.valid && (req.func == FUNC_TEST);
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      corner_x[req.vertex_index] <= req.x_coord;
      corner_y[req.vertex_index] <= req.y_coord;
    end

    // Stage 1: box test and differences, taken against the store as it stands at acceptance.
    if (rdy1) begin
      s1_box_out <= (req.x_coord < box_min_x) || (req.x_coord > box_max_x) ||
                    (req.y_coord < box_min_y) || (req.y_coord > box_max_y);
      s1_qx      <= DW'(req.x_coord) - DW'(center_x);
      s1_qy      <= DW'(req.y_coord) - DW'(center_y);
      s1_en      <= lane_en;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        s1_ex[i] <= DW'(end_x[i]) - DW'(corner_x[i]);
        s1_ey[i] <= DW'(end_y[i]) - DW'(corner_y[i]);
        s1_dx[i] <= DW'(req.x_coord) - DW'(corner_x[i]);
        s1_dy[i] <= DW'(req.y_coord) - DW'(corner_y[i]);
      end
    end

    // Stage 2: products.
    if (rdy2) begin
      s2_box_out <= s1_box_out;
      s2_en      <= s1_en;
      s2_sqx     <= s1_qx * s1_qx;
      s2_sqy     <= s1_qy * s1_qy;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        s2_pa[i] <= s1_ex[i] * s1_dy[i];
        s2_pb[i] <= s1_ey[i] * s1_dx[i];
      end
    end

    // Stage 3: per-edge sign test and squared distance.
    if (rdy3) begin
      s3_box_out <= s2_box_out;
      s3_dist    <= SUM_W'($unsigned(s2_sqx)) + SUM_W'($unsigned(s2_sqy));
      for (int i = 0; i < MAX_VERTICES; i++) begin
        s3_rej[i] <= s2_en[i] && (s2_pa[i] > s2_pb[i]);
      end
    end

    // Stage 4: the box and the outer circle win over the inner one, which wins over the edges.
    if (rdy4) begin
      inside_res <= !s3_box_out &&
                    !(CMP_W'(s3_dist) > CMP_W'(outer_radius_sq)) &&
                    ((CMP_W'(s3_dist) < CMP_W'(inner_radius_sq)) || !(|s3_rej));
    end
  end

endmodule

FILE: hdl/cppt_checker.sv
module cppt_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic req_func,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_inside_res
);
  import cppt_pkg::*;

  logic test_acc;
  assign test_acc = req_valid && req_ready && (req_func == FUNC_TEST);

  // A result waiting at the output keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inside_res))
    else $error("result dropped or changed while stalled");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result shown right after reset");

  // With nothing waiting at the output, the pipeline has room.
  assert property (@(posedge clk) disable iff (rst) !rsp_valid |-> req_ready)
    else $error("input stalled with empty output");

  // With the output always taken, an accepted point test is sure to come out.
  assert property (@(posedge clk) disable iff (rst)
    test_acc ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
    else $error("point test result late or missing");

endmodule

bind convex_polygon_point_test_top cppt_checker u_cppt_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_func       (req.func),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_inside_res (rsp.inside_res)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cppt_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE      = 8;
  localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = '1;
  localparam real PI = 3.14159265358979;

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

  typedef struct {
    coord_t                 min_x, max_x, min_y, max_y, ctr_x, ctr_y;
    logic [RADIUS_BITS-1:0] outer_sq, inner_sq;
  } region_t;

  typedef struct {
    coord_t px, py;
    bit     is_in;
  } verdict_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  cfg_index_t             cfg_index;
  logic [RADIUS_BITS-1:0] cfg_data;

  cppt_req_if req_if ();
  cppt_rsp_if rsp_if ();

  convex_polygon_point_test_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the block: registers, vertex store and vertex count.
  region_t    region;
  coord_t     vert_x [16];
  coord_t     vert_y [16];
  logic [4:0] vert_count;

  // Polygon currently being generated by the random phases.
  coord_t shape_x [16];
  coord_t shape_y [16];
  int     shape_n;
  int     shape_r;
  coord_t shape_cx;
  coord_t shape_cy;

  verdict_t verdict_q[$];
  int       error_count  = 0;
  int       items_sent   = 0;
  int       cycle_count  = 0;
  int       hold_ticket  = 0;
  bit       no_gaps      = 0;
  bit       store_filled = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit edge_rejects(int a, int b, coord_t px, coord_t py);
    longint ex, ey, dx, dy;
    ex = longint'(vert_x[b]) - longint'(vert_x[a]);
    ey = longint'(vert_y[b]) - longint'(vert_y[a]);
    dx = longint'(px) - longint'(vert_x[a]);
    dy = longint'(py) - longint'(vert_y[a]);
    return ex * dy > ey * dx;
  endfunction

  function automatic bit point_inside(coord_t px, coord_t py);
    longint ox, oy, dist_sq;
    int     n;
    if (px < region.min_x || px > region.max_x || py < region.min_y || py > region.max_y)
      return 1'b0;
    ox = longint'(px) - longint'(region.ctr_x);
    oy = longint'(py) - longint'(region.ctr_y);
    dist_sq = ox * ox + oy * oy;
    if (dist_sq > longint'({30'd0, region.outer_sq}))
      return 1'b0;
    if (longint'({30'd0, region.inner_sq}) > dist_sq)
      return 1'b1;
    n = (vert_count > 16) ? 16 : int'(vert_count);
    if (n == 2)
      return !edge_rejects(0, 1, px, py);
    if (n >= 3) begin
      for (int i = 0; i < n; i++)
        if (edge_rejects(i, (i + 1 == n) ? 0 : i + 1, px, py))
          return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int draw_wait();
    if (no_gaps)
      return 0;
    case ($urandom_range(0, 3))
      0, 1: return 0;
      2: return $urandom_range(1, 3);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic int rand_span(int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > 32767)
      return 16'sh7fff;
    if (v < -32768)
      return 16'sh8000;
    return coord_t'(v);
  endfunction

  function automatic logic [RADIUS_BITS-1:0] widen(coord_t c);
    return {{(RADIUS_BITS - COORD_BITS_DEF){c[COORD_BITS_DEF-1]}}, c};
  endfunction

  function automatic region_t open_region();
    region_t r;
    r.min_x    = 16'sh8000;
    r.max_x    = 16'sh7fff;
    r.min_y    = 16'sh8000;
    r.max_y    = 16'sh7fff;
    r.ctr_x    = '0;
    r.ctr_y    = '0;
    r.outer_sq = RADIUS_MAX;
    r.inner_sq = '0;
    return r;
  endfunction

  // Valid is left high after acceptance so that a back-to-back transaction
  // needs no second assignment in the same time step.
  task automatic send_item(logic func, logic [3:0] idx, logic last, coord_t px, coord_t py);
    int       gap;
    verdict_t v;
    gap = draw_wait();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.func         <= func;
    req_if.vertex_index <= idx;
    req_if.last_vertex  <= last;
    req_if.x_coord      <= px;
    req_if.y_coord      <= py;
    do @(posedge clk); while (!req_if.ready);
    items_sent++;
    if (func == FUNC_LOAD) begin
      vert_x[idx] = px;
      vert_y[idx] = py;
      if (last)
        vert_count = {1'b0, idx} + 5'd1;
    end else begin
      v.px    = px;
      v.py    = py;
      v.is_in = point_inside(px, py);
      verdict_q = {verdict_q, v};
    end
  endtask

  task automatic load_vertex(logic [3:0] idx, logic last, coord_t px, coord_t py);
    send_item(FUNC_LOAD, idx, last, px, py);
  endtask

  task automatic probe(coord_t px, coord_t py);
    send_item(FUNC_TEST, 4'($urandom), 1'($urandom), px, py);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(cfg_index_t idx, logic [RADIUS_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic apply_region(region_t r);
    drain();
    put_reg(CFG_BOX_MIN_X, widen(r.min_x));
    put_reg(CFG_BOX_MAX_X, widen(r.max_x));
    put_reg(CFG_BOX_MIN_Y, widen(r.min_y));
    put_reg(CFG_BOX_MAX_Y, widen(r.max_y));
    put_reg(CFG_CENTER_X, widen(r.ctr_x));
    put_reg(CFG_CENTER_Y, widen(r.ctr_y));
    put_reg(CFG_OUTER_RADIUS_SQ, r.outer_sq);
    put_reg(CFG_INNER_RADIUS_SQ, r.inner_sq);
    cfg_write <= 1'b0;
    @(posedge clk);
    region = r;
  endtask

  // Roughly regular clockwise polygon around a random center.
  function automatic void build_shape(int n, int r);
    real base, step, ang;
    int  lim;
    lim      = 32767 - r - 2;
    shape_n  = n;
    shape_r  = r;
    shape_cx = coord_t'(rand_span(lim));
    shape_cy = coord_t'(rand_span(lim));
    base     = $urandom_range(0, 6283) / 1000.0;
    step     = 2.0 * PI / n;
    for (int k = 0; k < n; k++) begin
      ang = base - k * step + rand_span(30) / 100.0 * step;
      shape_x[k] = coord_t'(shape_cx + $rtoi(r * $cos(ang)));
      shape_y[k] = coord_t'(shape_cy + $rtoi(r * $sin(ang)));
    end
  endfunction

  function automatic region_t region_for_shape(int mode);
    region_t r;
    coord_t  lo_x, hi_x, lo_y, hi_y;
    longint  ri, rin;
    int      grow;
    lo_x = shape_x[0];
    hi_x = shape_x[0];
    lo_y = shape_y[0];
    hi_y = shape_y[0];
    for (int k = 1; k < shape_n; k++) begin
      if (shape_x[k] < lo_x) lo_x = shape_x[k];
      if (shape_x[k] > hi_x) hi_x = shape_x[k];
      if (shape_y[k] < lo_y) lo_y = shape_y[k];
      if (shape_y[k] > hi_y) hi_y = shape_y[k];
    end
    r.min_x    = lo_x;
    r.max_x    = hi_x;
    r.min_y    = lo_y;
    r.max_y    = hi_y;
    r.ctr_x    = shape_cx;
    r.ctr_y    = shape_cy;
    ri         = shape_r + 2;
    r.outer_sq = RADIUS_BITS'(ri * ri);
    rin        = $rtoi(shape_r * $cos(PI / shape_n)) - 2;
    r.inner_sq = (rin > 0) ? RADIUS_BITS'(rin * rin) : '0;
    case (mode)
      1: r = open_region();
      2: begin
        r.outer_sq = RADIUS_BITS'(4 * longint'(shape_r) * shape_r);
        r.inner_sq = '0;
      end
      3: begin
        // Box and circles scattered around the polygon, possibly inconsistent.
        grow       = shape_r / 4 + 1;
        r.min_x    = clamp_coord(longint'(lo_x) + rand_span(grow));
        r.max_x    = clamp_coord(longint'(hi_x) + rand_span(grow));
        r.min_y    = clamp_coord(longint'(lo_y) + rand_span(grow));
        r.max_y    = clamp_coord(longint'(hi_y) + rand_span(grow));
        r.outer_sq = RADIUS_BITS'($urandom_range(0, 4 * shape_r * shape_r));
        r.inner_sq = RADIUS_BITS'($urandom_range(0, shape_r * shape_r));
      end
      4: begin
        r.outer_sq = $urandom_range(0, 1) ? RADIUS_MAX : '0;
        r.inner_sq = $urandom_range(0, 1) ? RADIUS_MAX : '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void pick_point(output coord_t px, output coord_t py);
    int k, grow;
    grow = shape_r / 4 + 4;
    case ($urandom_range(0, 9))
      0: begin
        px = coord_t'($urandom);
        py = coord_t'($urandom);
      end
      1: begin
        k  = $urandom_range(0, shape_n - 1);
        px = clamp_coord(longint'(shape_x[k]) + rand_span(3));
        py = clamp_coord(longint'(shape_y[k]) + rand_span(3));
      end
      default: begin
        px = clamp_coord(longint'(shape_cx) + rand_span(shape_r + grow));
        py = clamp_coord(longint'(shape_cy) + rand_span(shape_r + grow));
      end
    endcase
  endfunction

  task automatic test_reset_values();
    probe(16'sd0, 16'sd0);
    probe(16'sd1, 16'sd0);
    probe(16'sd0, -16'sd1);
  endtask

  task automatic test_short_polygons();
    apply_region(open_region());
    probe(16'sh7fff, 16'sh8000);
    load_vertex(4'd0, 1'b1, 16'sd100, 16'sd100);
    probe(16'sh8000, 16'sh7fff);
    load_vertex(4'd1, 1'b1, 16'sd100, -16'sd100);
    probe(16'sd200, 16'sd0);
    probe(16'sd0, 16'sd0);
    // Two equal vertices make an edge that can never reject a point.
    load_vertex(4'd1, 1'b1, 16'sd100, 16'sd100);
    probe(16'sh7fff, 16'sd0);
  endtask

  task automatic test_edge_wrap();
    load_vertex(4'd0, 1'b0, 16'sd0, 16'sd0);
    load_vertex(4'd1, 1'b0, 16'sd0, 16'sd1000);
    load_vertex(4'd2, 1'b1, 16'sd1000, 16'sd0);
    probe(16'sd500, -16'sd1);
    probe(16'sd300, 16'sd300);
    probe(16'sd600, 16'sd600);
  endtask

  task automatic test_circle_and_box();
    region_t r;
    r.min_x    = 16'sd0;
    r.max_x    = 16'sd1000;
    r.min_y    = 16'sd0;
    r.max_y    = 16'sd1000;
    r.ctr_x    = 16'sd600;
    r.ctr_y    = 16'sd600;
    r.outer_sq = 34'd600000;
    r.inner_sq = 34'd40000;
    apply_region(r);
    probe(16'sd600, 16'sd600);
    probe(16'sd300, 16'sd300);
    probe(16'sd0, 16'sd0);
    probe(16'sd1000, 16'sd0);
    probe(-16'sd1, 16'sd500);
  endtask

  task automatic test_extreme_square();
    apply_region(open_region());
    load_vertex(4'd0, 1'b0, 16'sh8000, 16'sh8000);
    load_vertex(4'd1, 1'b0, 16'sh8000, 16'sh7fff);
    load_vertex(4'd2, 1'b0, 16'sh7fff, 16'sh7fff);
    load_vertex(4'd3, 1'b1, 16'sh7fff, 16'sh8000);
    probe(16'sh8000, 16'sh8000);
    probe(16'sh7fff, 16'sh7fff);
  endtask

  task automatic test_random_polygons(int count);
    int     stop_at, n, r, start, idx;
    coord_t px, py;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      n = ($urandom_range(0, 9) == 0) ? 2 : $urandom_range(3, 16);
      // The first polygon fills the whole store so no later test reads an
      // entry that was never written.
      if (!store_filled)
        n = 16;
      store_filled = 1'b1;
      r = ($urandom_range(0, 7) == 0) ? $urandom_range(2000, 12000) : $urandom_range(4, 2000);
      build_shape(n, r);
      apply_region(region_for_shape($urandom_range(0, 4)));
      no_gaps = ($urandom_range(0, 3) == 0);
      start = $urandom_range(0, n - 1);
      for (int j = 0; j < n; j++) begin
        idx = (start + j) % n;
        load_vertex(4'(idx), idx == n - 1, shape_x[idx], shape_y[idx]);
      end
      repeat ($urandom_range(20, 80)) begin
        case ($urandom_range(0, 19))
          0: load_vertex(4'($urandom), $urandom_range(0, 3) == 0,
                         coord_t'($urandom), coord_t'($urandom));
          1: begin
            drain();
            pick_point(px, py);
            probe(px, py);
          end
          default: begin
            pick_point(px, py);
            probe(px, py);
          end
        endcase
      end
    end
    no_gaps = 1'b0;
  endtask

  // The result side holds off for a long stretch while queries keep coming,
  // so the pipeline fills and the request side stalls.
  task automatic test_output_stall();
    coord_t px, py;
    drain();
    no_gaps = 1'b1;
    hold_ticket++;
    repeat (40) begin
      pick_point(px, py);
      probe(px, py);
    end
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_write           <= 1'b0;
    cfg_index           <= CFG_BOX_MIN_X;
    cfg_data            <= '0;
    req_if.valid        <= 1'b0;
    req_if.func         <= FUNC_LOAD;
    req_if.vertex_index <= '0;
    req_if.last_vertex  <= 1'b0;
    req_if.x_coord      <= '0;
    req_if.y_coord      <= '0;
    region     = '{default: '0};
    vert_count = '0;
    for (int k = 0; k < 16; k++) begin
      vert_x[k] = '0;
      vert_y[k] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_short_polygons();
    test_edge_wrap();
    test_circle_and_box();
    test_extreme_square();
    test_random_polygons(800);
    test_output_stall();
    test_random_polygons(800);
    drain();
    if (error_count == 0)
      $display("** convex_polygon_point_test_top: PASSED **");
    else
      $display("** convex_polygon_point_test_top: FAILED **");
    $finish;
  end

  initial begin
    int stall_left, hold_left, served;
    stall_left = 0;
    hold_left  = 0;
    served     = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready)
        stall_left = draw_wait();
      if (served != hold_ticket) begin
        served    = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t ns: result with no query waiting, expected none, got inside_res=%0b",
                 $time, rsp_if.inside_res);
        error_count++;
      end else begin
        want = verdict_q.pop_front();
        if (rsp_if.inside_res !== want.is_in) begin
          $display("%0t ns: point (%0d,%0d) inside_res expected %0b, got %0b",
                   $time, want.px, want.py, want.is_in, rsp_if.inside_res);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, verdict_q.size());
      $display("** convex_polygon_point_test_top: FAILED **");
      $finish;
    end
  end

endmodule

FILE: files.f
hdl/cppt_pkg.sv
hdl/cppt_req_if.sv
hdl/cppt_rsp_if.sv
hdl/convex_polygon_point_test_top.sv
hdl/cppt_checker.sv
sim/tb_top.sv
